// ----- hdl/fot_pkg.sv -----
// Shared types and widths for the facet occlusion test core.
// Depends on nothing; every other file of the block imports it.
package fot_pkg;

    // Coordinate width of every input field and source register
    localparam int COORD_WIDTH = 16;

    // Derived widths of the exact integer datapath
    localparam int DIFF_W  = COORD_WIDTH + 1;   // vertex minus vertex or source
    localparam int SUM_W   = COORD_WIDTH + 3;   // three-times-scaled differences
    localparam int CROSS_W = 2 * DIFF_W + 1;    // cross product component
    localparam int PROD_W  = CROSS_W + SUM_W;   // one dot product term
    localparam int DOT_W   = PROD_W + 2;        // sum of three terms

    // Register stages from the item input to the result strobe
    localparam int LATENCY = 5;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SRC_X = 2'd0,
        CFG_SRC_Y = 2'd1,
        CFG_SRC_Z = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        t_coord vert_a_x;
        t_coord vert_a_y;
        t_coord vert_a_z;
        t_coord vert_b_x;
        t_coord vert_b_y;
        t_coord vert_b_z;
        t_coord vert_c_x;
        t_coord vert_c_y;
        t_coord vert_c_z;
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
    } t_item;

    typedef struct packed {
        logic behind_plane;
        logic inside_pyramid;
        logic occluded;
    } t_result;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } t_dvec;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } t_svec;

    typedef struct packed {
        logic signed [CROSS_W-1:0] x;
        logic signed [CROSS_W-1:0] y;
        logic signed [CROSS_W-1:0] z;
    } t_cvec;

    // Sign of a dot product; both clear means exactly zero
    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

endpackage

// ----- hdl/facet_occlusion_test_core.sv -----
// Facet occlusion test core: plane-side and pyramid tests, exact integers.
// Depends on fot_pkg, fot_cross and fot_dot_sign.
// The result strobe o_done leaves the output register with o_result, behind stage 1, cross and dot stages.
// Throughput: one transaction per cycle; five register stages, no stalls.
// o_busy stays low; the receiver cannot stall, so results are never held.
// Reset (synchronous, active low) clears the source registers and valid bits.
module facet_occlusion_test_core import fot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_start,
    input  t_item       i_item,
    output logic        o_busy,
    output logic        o_done,
    output t_result     o_result,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  t_coord      i_cfg_data
);

    t_coord r_src_x, r_src_y, r_src_z;
    logic   w_accept;

    // valid bits of stages 1..4 and the output stage
    logic [LATENCY-2:0] r_vld;
    logic               r_done;

    // stage 1 registers
    t_dvec r_e1, r_e2, r_as, r_bs, r_cs_d, r_ps;
    t_svec r_cs, r_pc;
    t_dvec n_e1, n_e2, n_as, n_bs, n_cs_d, n_ps;
    t_svec n_cs, n_pc;

    // stage 2 registers (cross outputs live in fot_cross)
    t_cvec w_n, w_d0, w_d1, w_d2;
    t_svec r_cs2, r_pc2, r_ps2;

    // stage 4 signs
    t_sign w_f, w_g, w_s0, w_s1, w_s2;

    t_result n_result;
    t_result r_result;

    assign w_accept    = i_start && !o_busy;
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Source registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_x <= '0;
            r_src_y <= '0;
            r_src_z <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SRC_X: r_src_x <= i_cfg_data;
                CFG_SRC_Y: r_src_y <= i_cfg_data;
                CFG_SRC_Z: r_src_z <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Stage 1: edges, vertex-minus-source, scaled centroid differences
    always_comb begin
        n_e1.x = DIFF_W'(i_item.vert_b_x) - DIFF_W'(i_item.vert_a_x);
        n_e1.y = DIFF_W'(i_item.vert_b_y) - DIFF_W'(i_item.vert_a_y);
        n_e1.z = DIFF_W'(i_item.vert_b_z) - DIFF_W'(i_item.vert_a_z);
        n_e2.x = DIFF_W'(i_item.vert_c_x) - DIFF_W'(i_item.vert_a_x);
        n_e2.y = DIFF_W'(i_item.vert_c_y) - DIFF_W'(i_item.vert_a_y);
        n_e2.z = DIFF_W'(i_item.vert_c_z) - DIFF_W'(i_item.vert_a_z);

        n_as.x = DIFF_W'(i_item.vert_a_x) - DIFF_W'(r_src_x);
        n_as.y = DIFF_W'(i_item.vert_a_y) - DIFF_W'(r_src_y);
        n_as.z = DIFF_W'(i_item.vert_a_z) - DIFF_W'(r_src_z);
        n_bs.x = DIFF_W'(i_item.vert_b_x) - DIFF_W'(r_src_x);
        n_bs.y = DIFF_W'(i_item.vert_b_y) - DIFF_W'(r_src_y);
        n_bs.z = DIFF_W'(i_item.vert_b_z) - DIFF_W'(r_src_z);
        n_cs_d.x = DIFF_W'(i_item.vert_c_x) - DIFF_W'(r_src_x);
        n_cs_d.y = DIFF_W'(i_item.vert_c_y) - DIFF_W'(r_src_y);
        n_cs_d.z = DIFF_W'(i_item.vert_c_z) - DIFF_W'(r_src_z);
        n_ps.x = DIFF_W'(i_item.point_x) - DIFF_W'(r_src_x);
        n_ps.y = DIFF_W'(i_item.point_y) - DIFF_W'(r_src_y);
        n_ps.z = DIFF_W'(i_item.point_z) - DIFF_W'(r_src_z);

        // centroid times three minus source times three, and 3P minus it
        n_cs.x = (SUM_W'(i_item.vert_a_x) + SUM_W'(i_item.vert_b_x)
                  + SUM_W'(i_item.vert_c_x))
                 - ((SUM_W'(r_src_x) <<< 1) + SUM_W'(r_src_x));
        n_cs.y = (SUM_W'(i_item.vert_a_y) + SUM_W'(i_item.vert_b_y)
                  + SUM_W'(i_item.vert_c_y))
                 - ((SUM_W'(r_src_y) <<< 1) + SUM_W'(r_src_y));
        n_cs.z = (SUM_W'(i_item.vert_a_z) + SUM_W'(i_item.vert_b_z)
                  + SUM_W'(i_item.vert_c_z))
                 - ((SUM_W'(r_src_z) <<< 1) + SUM_W'(r_src_z));
        n_pc.x = ((SUM_W'(i_item.point_x) <<< 1) + SUM_W'(i_item.point_x))
                 - (SUM_W'(i_item.vert_a_x) + SUM_W'(i_item.vert_b_x)
                    + SUM_W'(i_item.vert_c_x));
        n_pc.y = ((SUM_W'(i_item.point_y) <<< 1) + SUM_W'(i_item.point_y))
                 - (SUM_W'(i_item.vert_a_y) + SUM_W'(i_item.vert_b_y)
                    + SUM_W'(i_item.vert_c_y));
        n_pc.z = ((SUM_W'(i_item.point_z) <<< 1) + SUM_W'(i_item.point_z))
                 - (SUM_W'(i_item.vert_a_z) + SUM_W'(i_item.vert_b_z)
                    + SUM_W'(i_item.vert_c_z));
    end

    always_ff @(posedge i_clk) begin
        r_e1   <= n_e1;
        r_e2   <= n_e2;
        r_as   <= n_as;
        r_bs   <= n_bs;
        r_cs_d <= n_cs_d;
        r_ps   <= n_ps;
        r_cs   <= n_cs;
        r_pc   <= n_pc;
    end

    // Stage 2: normal and the three side normals through the source
    fot_cross u_cross_n  (.i_clk(i_clk), .i_u(r_e1),   .i_v(r_e2),   .o_c(w_n));
    fot_cross u_cross_d0 (.i_clk(i_clk), .i_u(r_bs),   .i_v(r_cs_d), .o_c(w_d0));
    fot_cross u_cross_d1 (.i_clk(i_clk), .i_u(r_cs_d), .i_v(r_as),   .o_c(w_d1));
    fot_cross u_cross_d2 (.i_clk(i_clk), .i_u(r_as),   .i_v(r_bs),   .o_c(w_d2));

    // Align the second dot operands with the cross outputs
    always_ff @(posedge i_clk) begin
        r_cs2   <= r_cs;
        r_pc2   <= r_pc;
        r_ps2.x <= SUM_W'(r_ps.x);
        r_ps2.y <= SUM_W'(r_ps.y);
        r_ps2.z <= SUM_W'(r_ps.z);
    end

    // Stages 3 and 4: dot product signs
    fot_dot_sign u_dot_f  (.i_clk(i_clk), .i_a(w_n),  .i_b(r_cs2), .o_sign(w_f));
    fot_dot_sign u_dot_g  (.i_clk(i_clk), .i_a(w_n),  .i_b(r_pc2), .o_sign(w_g));
    fot_dot_sign u_dot_s0 (.i_clk(i_clk), .i_a(w_d0), .i_b(r_ps2), .o_sign(w_s0));
    fot_dot_sign u_dot_s1 (.i_clk(i_clk), .i_a(w_d1), .i_b(r_ps2), .o_sign(w_s1));
    fot_dot_sign u_dot_s2 (.i_clk(i_clk), .i_a(w_d2), .i_b(r_ps2), .o_sign(w_s2));

    // Stage 5: flags; a zero facing product counts as facing away
    always_comb begin
        n_result.behind_plane   = w_f.pos ? w_g.pos : w_g.neg;
        n_result.inside_pyramid = (w_s0.pos && w_s1.pos && w_s2.pos)
                                  || (w_s0.neg && w_s1.neg && w_s2.neg);
        n_result.occluded       = n_result.behind_plane && n_result.inside_pyramid;
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[LATENCY-3:0], w_accept};
            r_done <= r_vld[LATENCY-2];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Every accepted transaction yields a strobe after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##5 o_done)
        else $error("result strobe missing after accept");

    // No strobe without an accepted transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_accept) |-> ##5 !o_done)
        else $error("result strobe without accepted transaction");

    // A degenerate triangle can never be reported as behind the plane
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && w_n == '0) |-> ##3 !o_result.behind_plane)
        else $error("degenerate triangle flagged behind plane");

    // occluded is the AND of both tests
    a_occluded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.occluded
                    == (o_result.behind_plane && o_result.inside_pyramid)))
        else $error("occluded flag mismatch");

endmodule

// ----- hdl/fot_cross.sv -----
// Registered exact cross product of two difference vectors.
// Depends on fot_pkg for the vector types.
module fot_cross import fot_pkg::*; (
    input  logic  i_clk,
    input  t_dvec i_u,
    input  t_dvec i_v,
    output t_cvec o_c
);

    logic signed [2*DIFF_W-1:0] w_yz, w_zy, w_zx, w_xz, w_xy, w_yx;
    t_cvec n_c;
    t_cvec r_c;

    // Six partial products
    assign w_yz = i_u.y * i_v.z;
    assign w_zy = i_u.z * i_v.y;
    assign w_zx = i_u.z * i_v.x;
    assign w_xz = i_u.x * i_v.z;
    assign w_xy = i_u.x * i_v.y;
    assign w_yx = i_u.y * i_v.x;

    // Component differences, one bit wider than a product
    always_comb begin
        n_c.x = CROSS_W'(w_yz) - CROSS_W'(w_zy);
        n_c.y = CROSS_W'(w_zx) - CROSS_W'(w_xz);
        n_c.z = CROSS_W'(w_xy) - CROSS_W'(w_yx);
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
    end

    assign o_c = r_c;

endmodule

// ----- hdl/fot_dot_sign.sv -----
// Two-stage exact dot product sign: products, then sum and sign.
// Depends on fot_pkg for vector and sign types.
module fot_dot_sign import fot_pkg::*; (
    input  logic  i_clk,
    input  t_cvec i_a,
    input  t_svec i_b,
    output t_sign o_sign
);

    logic signed [PROD_W-1:0] n_px, n_py, n_pz;
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic signed [DOT_W-1:0]  w_sum;
    t_sign n_sign;
    t_sign r_sign;

    // Stage A: three products
    assign n_px = i_a.x * i_b.x;
    assign n_py = i_a.y * i_b.y;
    assign n_pz = i_a.z * i_b.z;

    always_ff @(posedge i_clk) begin
        r_px <= n_px;
        r_py <= n_py;
        r_pz <= n_pz;
    end

    // Stage B: exact sum and its sign
    assign w_sum = DOT_W'(r_px) + DOT_W'(r_py) + DOT_W'(r_pz);

    always_comb begin
        n_sign.neg = w_sum[DOT_W-1];
        n_sign.pos = !w_sum[DOT_W-1] && (w_sum != '0);
    end

    always_ff @(posedge i_clk) begin
        r_sign <= n_sign;
    end

    assign o_sign = r_sign;

endmodule

// ----- verif/tb_facet_occlusion_test_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for facet_occlusion_test_core: directed facet pairs,
// coordinate extremes and random streams. Depends on fot_pkg and the core RTL.
module tb_facet_occlusion_test_core import fot_pkg::*; ();

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< (COORD_WIDTH - 1));
    localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = LATENCY + 4;
    localparam int ITEMS_PER_BLOCK = 50;
    localparam int BLOCKS_PER_STREAM = 4;

    typedef longint t_vec3 [3];

    // How the random generator places a facet pair
    typedef enum int {
        SHAPE_THROUGH,
        SHAPE_EDGE,
        SHAPE_ON_PLANE,
        SHAPE_DEGENERATE,
        SHAPE_SRC_IN_PLANE
    } t_pair_shape;

    // How a source setting is picked
    typedef enum int {
        SRC_EXTREME,
        SRC_NEAR,
        SRC_WIDE
    } t_src_style;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_start;
    t_item      i_item;
    logic       o_busy;
    logic       o_done;
    t_result    o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    t_coord     i_cfg_data;

    t_coord  src_pos [3];          // source registers as the core should hold them
    t_result occl_expect_q [$];    // predicted flags, oldest first
    int      n_mismatch = 0;

    facet_occlusion_test_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void cross3(input t_vec3 u, input t_vec3 v, output t_vec3 r);
        r[0] = u[1] * v[2] - u[2] * v[1];
        r[1] = u[2] * v[0] - u[0] * v[2];
        r[2] = u[0] * v[1] - u[1] * v[0];
    endfunction

    // Exact sign of a dot product, summed wide enough to never wrap
    function automatic int dot_sign(input t_vec3 x, input t_vec3 y);
        logic signed [127:0] acc;
        logic signed [127:0] xw;
        logic signed [127:0] yw;
        acc = '0;
        for (int j = 0; j < 3; j++) begin
            xw = x[j];
            yw = y[j];
            acc = acc + xw * yw;
        end
        return (acc > 0) ? 1 : ((acc < 0) ? -1 : 0);
    endfunction

    function automatic t_result predict_occlusion(input t_item it);
        longint  vt [3][3];
        t_vec3   pt, sp, e1, e2, nrm, cs, pc, u, w, cr;
        longint  c3;
        int      facing, side, d, npos, nneg;
        t_result r;
        vt[0] = '{it.vert_a_x, it.vert_a_y, it.vert_a_z};
        vt[1] = '{it.vert_b_x, it.vert_b_y, it.vert_b_z};
        vt[2] = '{it.vert_c_x, it.vert_c_y, it.vert_c_z};
        pt = '{it.point_x, it.point_y, it.point_z};
        // plane side, with centroid and point scaled by three
        for (int j = 0; j < 3; j++) begin
            sp[j] = src_pos[j];
            c3 = vt[0][j] + vt[1][j] + vt[2][j];
            e1[j] = vt[1][j] - vt[0][j];
            e2[j] = vt[2][j] - vt[0][j];
            cs[j] = c3 - 3 * sp[j];
            pc[j] = 3 * pt[j] - c3;
        end
        cross3(e1, e2, nrm);
        facing = dot_sign(cs, nrm);
        side = dot_sign(nrm, pc);
        // a zero facing product counts as facing away
        r.behind_plane = (facing > 0) ? (side > 0) : (side < 0);
        // pyramid: all three side products strictly of one sign
        npos = 0;
        nneg = 0;
        for (int j = 0; j < 3; j++)
            pc[j] = pt[j] - sp[j];
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                u[j] = vt[(k + 1) % 3][j] - sp[j];
                w[j] = vt[(k + 2) % 3][j] - sp[j];
            end
            cross3(u, w, cr);
            d = dot_sign(cr, pc);
            if (d > 0)
                npos++;
            else if (d < 0)
                nneg++;
        end
        r.inside_pyramid = (npos == 3) || (nneg == 3);
        r.occluded = r.behind_plane && r.inside_pyramid;
        return r;
    endfunction

    // ---------------------------------------------------------------- item building

    function automatic t_coord clamp_coord(input longint v);
        if (v > COORD_MAX)
            return t_coord'(COORD_MAX);
        if (v < COORD_MIN)
            return t_coord'(COORD_MIN);
        return t_coord'(v);
    endfunction

    function automatic t_item make_item(input longint ax, ay, az, bx, by, bz,
                                        cx, cy, cz, px, py, pz);
        t_item it;
        it.vert_a_x = clamp_coord(ax);
        it.vert_a_y = clamp_coord(ay);
        it.vert_a_z = clamp_coord(az);
        it.vert_b_x = clamp_coord(bx);
        it.vert_b_y = clamp_coord(by);
        it.vert_b_z = clamp_coord(bz);
        it.vert_c_x = clamp_coord(cx);
        it.vert_c_y = clamp_coord(cy);
        it.vert_c_z = clamp_coord(cz);
        it.point_x  = clamp_coord(px);
        it.point_y  = clamp_coord(py);
        it.point_z  = clamp_coord(pz);
        return it;
    endfunction

    function automatic longint rand_near(input longint center, input int span);
        return center + longint'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly a point on a ray from the source through the triangle, at a random depth
    function automatic t_item random_facet_pair();
        longint      va [3], vb [3], vc [3], q [3], pt [3], sp [3];
        longint      ctr, tn;
        int          span, wa, wb, wc, pick;
        t_pair_shape shape;
        pick = $urandom_range(99);
        if (pick < 60)
            shape = SHAPE_THROUGH;
        else if (pick < 70)
            shape = SHAPE_EDGE;
        else if (pick < 80)
            shape = SHAPE_ON_PLANE;
        else if (pick < 90)
            shape = SHAPE_DEGENERATE;
        else
            shape = SHAPE_SRC_IN_PLANE;
        case ($urandom_range(2))
            0:       span = 100;
            1:       span = 2000;
            default: span = 8000;
        endcase
        wa = $urandom_range(1, 8);
        wb = $urandom_range(1, 8);
        wc = $urandom_range(1, 8);
        tn = $urandom_range(1, 12);
        for (int j = 0; j < 3; j++) begin
            sp[j] = src_pos[j];
            ctr = rand_near(0, 12000);
            va[j] = rand_near(ctr, span);
            vb[j] = rand_near(ctr, span);
            vc[j] = rand_near(ctr, span);
            if (shape == SHAPE_DEGENERATE)
                vc[j] = va[j] + 2 * (vb[j] - va[j]);
            if (shape == SHAPE_SRC_IN_PLANE) begin
                va[j] = sp[j] + rand_near(0, span);
                vb[j] = sp[j] + rand_near(0, span);
                vc[j] = va[j] + vb[j] - sp[j];
            end
            q[j] = (wa * va[j] + wb * vb[j] + wc * vc[j]) / (wa + wb + wc);
            pt[j] = sp[j] + (q[j] - sp[j]) * tn / 4;
            // exactly in the plane of the source and edge AB
            if (shape == SHAPE_EDGE)
                pt[j] = va[j] + vb[j] - sp[j];
            // exactly in the triangle's own plane
            if (shape == SHAPE_ON_PLANE)
                pt[j] = vb[j] + vc[j] - va[j];
        end
        return make_item(va[0], va[1], va[2], vb[0], vb[1], vb[2],
                         vc[0], vc[1], vc[2], pt[0], pt[1], pt[2]);
    endfunction

    function automatic t_coord pick_source_coord(input t_src_style style);
        case (style)
            SRC_EXTREME: begin
                case ($urandom_range(2))
                    0:       return t_coord'(COORD_MAX);
                    1:       return t_coord'(COORD_MIN);
                    default: return '0;
                endcase
            end
            SRC_NEAR: return clamp_coord(rand_near(0, 100));
            default:  return t_coord'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    // Item transaction: hold start until accepted, then log the prediction
    task automatic send_item(input t_item it);
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        occl_expect_q.push_back(predict_occlusion(it));
    endtask

    task automatic sender_gap(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_start <= 1'b0;
        while (occl_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Config transaction; valid stays high so writes can go back to back
    task automatic cfg_write(input logic [1:0] idx, input t_coord data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SRC_X: src_pos[0] = data;
            CFG_SRC_Y: src_pos[1] = data;
            CFG_SRC_Z: src_pos[2] = data;
            default: ;  // unused index, no register behind it
        endcase
    endtask

    task automatic write_source(input t_coord sx, input t_coord sy, input t_coord sz);
        cfg_write(CFG_SRC_X, sx);
        cfg_write(CFG_SRC_Y, sy);
        cfg_write(CFG_SRC_Z, sz);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (occl_expect_q.size() == 0) begin
                $display("%0t: unexpected result behind=%0b inside=%0b occluded=%0b",
                         $realtime, o_result.behind_plane, o_result.inside_pyramid,
                         o_result.occluded);
                n_mismatch++;
            end else begin
                want = occl_expect_q.pop_front();
                if (o_result.behind_plane !== want.behind_plane ||
                    o_result.inside_pyramid !== want.inside_pyramid ||
                    o_result.occluded !== want.occluded) begin
                    $display("%0t: mismatch expected behind=%0b inside=%0b occluded=%0b",
                             $realtime, want.behind_plane, want.inside_pyramid,
                             want.occluded);
                    $display("%0t:            actual behind=%0b inside=%0b occluded=%0b",
                             $realtime, o_result.behind_plane, o_result.inside_pyramid,
                             o_result.occluded);
                    n_mismatch++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Source at its reset position; mostly a triangle in the plane z = 100
    task automatic test_plane_and_pyramid();
        send_item(make_item(-100, -100, 100, 100, -100, 100, 0, 100, 100, 0, 0, 200));
        send_item(make_item(-100, -100, 100, 100, -100, 100, 0, 100, 100, 0, 0, 50));
        send_item(make_item(-100, -100, 100, 100, -100, 100, 0, 100, 100, 0, 0, -200));
        send_item(make_item(-100, -100, 100, 100, -100, 100, 0, 100, 100, 500, 0, 200));
        // on a side face of the pyramid, and along a vertex ray
        send_item(make_item(-100, -100, 100, 100, -100, 100, 0, 100, 100, 0, -200, 200));
        send_item(make_item(-100, -100, 100, 100, -100, 100, 0, 100, 100, -200, -200, 200));
        // point in the triangle's plane
        send_item(make_item(-100, -100, 100, 100, -100, 100, 0, 100, 100, 0, 0, 100));
        // reversed winding
        send_item(make_item(0, 100, 100, 100, -100, 100, -100, -100, 100, 0, 0, 200));
        // collinear vertices: no normal
        send_item(make_item(1, 1, 1, 2, 2, 2, 3, 3, 3, 5, 7, 9));
        // source lies in the triangle's plane
        send_item(make_item(-100, -100, 0, 100, -100, 0, 0, 100, 0, 0, 0, -50));
        send_item(make_item(-100, -100, 0, 100, -100, 0, 0, 100, 0, 0, 0, 50));
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_coordinate_extremes();
        wait_results_drained();
        cfg_write(CFG_SRC_X, t_coord'(COORD_MAX));
        cfg_write(CFG_SRC_Y, t_coord'(COORD_MIN));
        cfg_write(CFG_SRC_Z, t_coord'(COORD_MAX));
        // a write to the unused index must leave the source alone
        cfg_write(CFG_IDX_UNUSED, '0);
        i_cfg_valid <= 1'b0;
        send_item(make_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX));
        send_item(make_item(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN));
        send_item(make_item(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
                            COORD_MAX, COORD_MIN));
        send_item(make_item(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                            COORD_MAX, COORD_MAX));
        send_item(make_item(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                            COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                            COORD_MAX, COORD_MIN));
        wait_results_drained();
        write_source(t_coord'(COORD_MIN), t_coord'(COORD_MIN), t_coord'(COORD_MIN));
        send_item(make_item(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                            COORD_MAX, COORD_MAX));
        send_item(make_item(0, 0, COORD_MAX, COORD_MAX, 0, COORD_MAX, 0, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_item(make_item(COORD_MIN, COORD_MAX, 0, COORD_MAX, COORD_MIN, 0, 0, 0,
                            COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
    endtask

    // Blocks of random pairs, each under a fresh source, sender idling at idle_pct
    task automatic test_random_stream(input int idle_pct);
        t_src_style style;
        bit         calm;
        for (int b = 0; b < BLOCKS_PER_STREAM; b++) begin
            wait_results_drained();
            style = (b == 0) ? SRC_EXTREME : t_src_style'($urandom_range(2));
            write_source(pick_source_coord(style), pick_source_coord(style),
                         pick_source_coord(style));
            calm = 1'b0;
            for (int i = 0; i < ITEMS_PER_BLOCK; i++) begin
                // some stretches run back to back
                if (i % 25 == 0)
                    calm = ($urandom_range(2) == 0);
                if (!calm && $urandom_range(99) < idle_pct)
                    sender_gap($urandom_range(1, 4));
                if ($urandom_range(99) < 30)
                    send_item(t_item'({$urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom}));
                else
                    send_item(random_facet_pair());
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SRC_X;
        i_cfg_data  <= '0;
        src_pos = '{'0, '0, '0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plane_and_pyramid();
        test_coordinate_extremes();
        test_random_stream(15);
        test_random_stream(50);
        test_random_stream(0);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && occl_expect_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin
        #(200_000 * 20);
        $display("FAILURE");
        $finish;
    end

endmodule
